@@ rtl/dwrp_pkg.sv @@
// shared types and constants of the detector word run packer
package dwrp_pkg;

  localparam int FRAME_BYTES_DEF = 256;
  localparam int IQ_DEPTH        = 2;
  localparam int OQ_DEPTH        = 4;
  localparam int OQ_CW           = $clog2(OQ_DEPTH + 1);
  localparam int SPLIT_COUNT     = 32768;
  localparam int ZERO_HOLD       = 8;

  // descriptor type codes as they appear in the frame
  localparam logic [1:0] DT_BYTE = 2'd0;
  localparam logic [1:0] DT_LONG = 2'd1;
  localparam logic [1:0] DT_NULL = 2'd2;

  // configuration register index
  localparam logic REG_PACKING_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    RC_NONE,
    RC_ZERO,
    RC_SMALL,
    RC_LONG
  } run_class_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] data_word;
    logic        buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic [2:0]  valid_bytes;
    logic        frame_last;
    logic [6:0]  sequence_number;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    in_item_t   item;
    run_class_t cls;
    logic       pen;
  } cls_item_t;

endpackage

@@ rtl/dwrp_front.sv @@
// front end: accepts input items, classifies them and queues them for the back end
module dwrp_front import dwrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      packing_enable,
  output logic      q_valid,
  output cls_item_t q_item,
  input  logic      q_pop
);

  localparam int PW = $clog2(IQ_DEPTH);
  localparam int CW = $clog2(IQ_DEPTH + 1);

  cls_item_t       slot_r [IQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;
  cls_item_t       cls_w;

  // word class: zero, small (below 256) or long
  always_comb begin
    cls_w.item = in_item;
    cls_w.pen  = packing_enable;
    if (in_item.data_word == 32'd0) begin
      cls_w.cls = RC_ZERO;
    end else if (in_item.data_word[31:8] == 24'd0) begin
      cls_w.cls = RC_SMALL;
    end else begin
      cls_w.cls = RC_LONG;
    end
  end

  assign in_full = (cnt_r == CW'(IQ_DEPTH));
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cls_w;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(IQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(IQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

@@ rtl/dwrp_outq.sv @@
// result queue between the frame emitter and the result port
module dwrp_outq import dwrp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  out_item_t        push_data,
  input  logic             pop,
  output logic             empty,
  output out_item_t        head,
  output logic [OQ_CW-1:0] cnt
);

  localparam int PW = $clog2(OQ_DEPTH);

  out_item_t      slot_r [OQ_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r;
  logic           do_pop;

  assign empty  = (cnt_r == '0);
  assign head   = slot_r[rd_ptr_r];
  assign cnt    = cnt_r;
  assign do_pop = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers; the emitter only pushes when room is reserved
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + OQ_CW'(push) - OQ_CW'(do_pop);
    end
  end

endmodule

@@ rtl/dwrp_back.sv @@
// back end: run handling, frame packing into banked store, frame emission
module dwrp_back import dwrp_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cls_item_t        q_item,
  output logic             q_pop,
  input  logic [OQ_CW-1:0] oq_cnt,
  output logic             oq_push,
  output out_item_t        oq_data
);

  localparam int SPW        = $clog2(FRAME_BYTES + 1);
  localparam int DESC_SLOTS = FRAME_BYTES / 4 + 1;
  localparam int NW         = $clog2(DESC_SLOTS + 1);
  localparam int DAW        = $clog2(DESC_SLOTS);
  localparam int BANK_DEPTH = (FRAME_BYTES + 3) / 4;
  localparam int BAW        = $clog2(BANK_DEPTH);
  localparam int WW         = $clog2(FRAME_BYTES / 4 + 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FP1,
    ST_MAIN,
    ST_FP2,
    ST_HEAD,
    ST_DATA,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0] cnt;
    logic [1:0]  typ;
  } desc_t;

  // control state
  state_t           state_r, state_nxt, p_ret_r, p_ret_nxt, e_ret_r, e_ret_nxt;
  cls_item_t        itm_r, itm_nxt;
  logic             chg_r, chg_nxt;
  run_class_t       run_class_r, run_class_nxt, pend_type_r, pend_type_nxt;
  logic [3:0]       pend_len_r, pend_len_nxt;
  logic [7:0]       pend_b0_r, pend_b0_nxt, pend_b1_r, pend_b1_nxt;
  logic [1:0]       p_type_r, p_type_nxt;
  logic [3:0]       p_cnt_r, p_cnt_nxt, p_tc_r, p_tc_nxt;
  logic [63:0]      p_bytes_r, p_bytes_nxt;
  logic [NW-1:0]    desc_total_r, desc_total_nxt;
  logic [1:0]       open_type_r, open_type_nxt;
  logic [15:0]      open_count_r, open_count_nxt;
  logic [SPW-1:0]   space_r, space_nxt, data_len_r, data_len_nxt;
  logic [7:0]       frame_cnt_r, frame_cnt_nxt;
  logic [WW-1:0]    ew_r, ew_nxt, s2_w_r, s2_w_nxt;
  logic             s2_v_r, s2_v_nxt;
  logic [1:0]       t_prev_r, t_prev_nxt;

  // memories
  desc_t            desc_mem [DESC_SLOTS];
  desc_t            desc_rd_r;
  logic [7:0]       bank_mem [4][BANK_DEPTH];
  logic [7:0]       bank_rd_r [4];

  logic             desc_we;
  logic [DAW-1:0]   desc_wa, desc_ra;
  logic             bank_we [4];
  logic [BAW-1:0]   bank_wa [4], bank_ra [4];
  logic [7:0]       bank_wd [4];
  logic             issue;

  // run close-out (finish of a pending run) as a pack call
  logic             fp_has, fp_ls, fp_empty, fp_v;
  logic [1:0]       fp_type;
  logic [3:0]       fp_cnt;
  logic [63:0]      fp_bytes;

  // pack call from the item phases
  logic             call_v;
  logic [1:0]       call_type;
  logic [3:0]       call_cnt;
  logic [63:0]      call_bytes;
  state_t           phase_next;
  logic             in_phase;

  // head / data step helpers
  logic             need_new;
  logic [SPW-1:0]   space_eff, space_dn;
  logic [15:0]      oc_base;
  logic [2:0]       chunk;
  logic [1:0]       off;
  logic [SPW-1:0]   widx;
  logic [31:0]      top_bytes;
  logic [7:0]       one;

  // emission helpers
  logic [SPW-1:0]   tot_bytes, rem_bytes;
  logic [WW-1:0]    words, n_w;
  logic             room;
  logic             cur_open;
  desc_t            cur_d;
  logic [15:0]      cur_shown;
  logic [7:0]       ob [4];
  logic [2:0]       vb;

  assign one       = itm_r.item.data_word[7:0];
  assign tot_bytes = SPW'(FRAME_BYTES) - space_r;
  assign words     = WW'(({1'b0, tot_bytes} + (SPW + 1)'(3)) >> 2);
  assign n_w       = WW'(desc_total_r);
  assign room      = ({1'b0, oq_cnt} + (OQ_CW + 1)'(s2_v_r)) < (OQ_CW + 1)'(OQ_DEPTH);

  // close-out rules for a pending zero or small run
  always_comb begin
    fp_has   = (state_r == ST_FP1) && itm_r.pen;
    fp_ls    = (itm_r.item.data_word[31:8] == 24'd0);
    fp_empty = (desc_total_r == '0);
    fp_v     = 1'b0;
    fp_type  = DT_NULL;
    fp_cnt   = pend_len_r;
    fp_bytes = '0;
    if (pend_type_r == RC_ZERO && pend_len_r != 4'd0 && pend_len_r <= 4'(ZERO_HOLD)) begin
      fp_v = 1'b1;
      if (!fp_empty && fp_has) begin
        if (open_type_r == DT_BYTE && fp_ls) begin
          fp_type = DT_BYTE;
        end else if ((open_type_r == DT_BYTE || fp_ls) && pend_len_r <= 4'd4) begin
          fp_type = DT_BYTE;
        end else if (open_type_r == DT_LONG && !fp_ls && pend_len_r <= 4'd2) begin
          fp_type = DT_LONG;
        end
      end else if (!fp_has) begin
        if (open_type_r == DT_BYTE && pend_len_r < 4'd4) begin
          fp_type = DT_BYTE;
        end else if (open_type_r == DT_LONG && pend_len_r < 4'd2) begin
          fp_type = DT_LONG;
        end
      end else begin
        if (fp_ls && pend_len_r < 4'd4) begin
          fp_type = DT_BYTE;
        end else if (!fp_ls && pend_len_r < 4'd2) begin
          fp_type = DT_LONG;
        end
      end
      if (fp_type == DT_LONG) begin
        fp_cnt = {pend_len_r[1:0], 2'b00};
      end
    end else if (pend_type_r == RC_SMALL && pend_len_r != 4'd0 && pend_len_r <= 4'd2) begin
      fp_v    = 1'b1;
      fp_type = DT_BYTE;
      if (!fp_empty && fp_has) begin
        if (open_type_r == DT_LONG || !fp_ls) begin
          fp_type = DT_LONG;
        end
      end else if (!fp_has) begin
        if (open_type_r == DT_LONG && pend_len_r == 4'd1) begin
          fp_type = DT_LONG;
        end
      end else begin
        if (!fp_ls && pend_len_r == 4'd1) begin
          fp_type = DT_LONG;
        end
      end
      if (fp_type == DT_LONG) begin
        fp_cnt   = {pend_len_r[1:0], 2'b00};
        fp_bytes = {24'd0, pend_b0_r, 24'd0, pend_b1_r};
      end else begin
        fp_bytes = {pend_b0_r, pend_b1_r, 48'd0};
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    p_ret_nxt      = p_ret_r;
    e_ret_nxt      = e_ret_r;
    itm_nxt        = itm_r;
    chg_nxt        = chg_r;
    run_class_nxt  = run_class_r;
    pend_type_nxt  = pend_type_r;
    pend_len_nxt   = pend_len_r;
    pend_b0_nxt    = pend_b0_r;
    pend_b1_nxt    = pend_b1_r;
    p_type_nxt     = p_type_r;
    p_cnt_nxt      = p_cnt_r;
    p_tc_nxt       = p_tc_r;
    p_bytes_nxt    = p_bytes_r;
    desc_total_nxt = desc_total_r;
    open_type_nxt  = open_type_r;
    open_count_nxt = open_count_r;
    space_nxt      = space_r;
    data_len_nxt   = data_len_r;
    frame_cnt_nxt  = frame_cnt_r;
    ew_nxt         = ew_r;
    q_pop          = 1'b0;
    call_v         = 1'b0;
    call_type      = DT_LONG;
    call_cnt       = 4'd4;
    call_bytes     = {itm_r.item.data_word, 32'd0};
    phase_next     = ST_IDLE;
    in_phase       = 1'b0;
    desc_we        = 1'b0;
    desc_wa        = DAW'(desc_total_r - NW'(1));
    need_new       = 1'b0;
    space_eff      = space_r;
    space_dn       = space_r;
    oc_base        = open_count_r;
    chunk          = 3'd0;
    issue          = 1'b0;
    for (int j = 0; j < 4; j++) begin
      bank_we[j] = 1'b0;
      bank_wa[j] = '0;
      bank_wd[j] = '0;
    end
    off       = 2'd0;
    widx      = '0;
    top_bytes = p_bytes_r[63:32];

    case (state_r)
      // take the next classified item
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          itm_nxt = q_item;
          if (q_item.item.operation) begin
            if (desc_total_r != '0) begin
              state_nxt = ST_EMIT;
              e_ret_nxt = ST_IDLE;
              ew_nxt    = '0;
            end
          end else if (!q_item.pen || q_item.cls != run_class_r) begin
            chg_nxt   = 1'b1;
            state_nxt = ST_FP1;
          end else begin
            chg_nxt   = 1'b0;
            state_nxt = ST_MAIN;
          end
        end
      end

      // close the pending run at a class change or with packing off
      ST_FP1: begin
        in_phase      = 1'b1;
        phase_next    = ST_MAIN;
        call_v        = fp_v;
        call_type     = fp_type;
        call_cnt      = fp_cnt;
        call_bytes    = fp_bytes;
        pend_type_nxt = RC_NONE;
        pend_len_nxt  = 4'd0;
        run_class_nxt = itm_r.pen ? itm_r.cls : RC_NONE;
      end

      // the word itself
      ST_MAIN: begin
        in_phase   = 1'b1;
        phase_next = (itm_r.pen && itm_r.item.buffer_end) ? ST_FP2 : ST_IDLE;
        if (!itm_r.pen || itm_r.cls == RC_LONG) begin
          call_v = 1'b1;
        end else if (chg_r) begin
          pend_type_nxt = itm_r.cls;
          pend_len_nxt  = 4'd1;
          pend_b0_nxt   = one;
        end else if (itm_r.cls == RC_ZERO) begin
          if (pend_type_r == RC_ZERO) begin
            pend_len_nxt = pend_len_r + 4'd1;
            if (pend_len_r + 4'd1 > 4'(ZERO_HOLD)) begin
              call_v        = 1'b1;
              call_type     = DT_NULL;
              call_cnt      = pend_len_r + 4'd1;
              pend_type_nxt = RC_NONE;
              pend_len_nxt  = 4'd0;
            end
          end else begin
            call_v    = 1'b1;
            call_type = DT_NULL;
            call_cnt  = 4'd1;
          end
        end else begin
          if (pend_type_r == RC_SMALL && pend_len_r < 4'd2) begin
            if (pend_len_r[0]) begin
              pend_b1_nxt = one;
            end else begin
              pend_b0_nxt = one;
            end
            pend_len_nxt = pend_len_r + 4'd1;
          end else if (pend_type_r == RC_SMALL) begin
            call_v        = 1'b1;
            call_type     = DT_BYTE;
            call_cnt      = 4'd3;
            call_bytes    = {pend_b0_r, pend_b1_r, one, 40'd0};
            pend_type_nxt = RC_NONE;
            pend_len_nxt  = 4'd0;
          end else begin
            call_v     = 1'b1;
            call_type  = DT_BYTE;
            call_cnt   = 4'd1;
            call_bytes = {one, 56'd0};
          end
        end
      end

      // close the pending run at a buffer end
      ST_FP2: begin
        in_phase      = 1'b1;
        phase_next    = ST_IDLE;
        call_v        = fp_v;
        call_type     = fp_type;
        call_cnt      = fp_cnt;
        call_bytes    = fp_bytes;
        pend_type_nxt = RC_NONE;
        pend_len_nxt  = 4'd0;
        run_class_nxt = RC_NONE;
      end

      // one pack iteration: descriptor decision
      ST_HEAD: begin
        need_new = (desc_total_r == '0) || (open_type_r != p_type_r) ||
                   (({1'b0, open_count_r} + 17'(p_cnt_r)) >= 17'(SPLIT_COUNT));
        if (p_cnt_r == 4'd0) begin
          state_nxt = p_ret_r;
        end else if (need_new && space_r < SPW'(8)) begin
          state_nxt = ST_EMIT;
          e_ret_nxt = ST_HEAD;
          ew_nxt    = '0;
        end else begin
          if (need_new) begin
            desc_we        = (desc_total_r != '0);
            desc_total_nxt = desc_total_r + NW'(1);
            open_type_nxt  = p_type_r;
            oc_base        = 16'd0;
            space_eff      = ((desc_total_r == '0) ? SPW'(FRAME_BYTES - 2) : space_r) - SPW'(4);
          end
          space_nxt = space_eff;
          if (p_type_r == DT_NULL) begin
            open_count_nxt = oc_base + 16'(p_cnt_r);
            p_cnt_nxt      = 4'd0;
            if (space_eff < SPW'(5)) begin
              state_nxt = ST_EMIT;
              e_ret_nxt = p_ret_r;
              ew_nxt    = '0;
            end else begin
              state_nxt = p_ret_r;
            end
          end else begin
            open_count_nxt = oc_base;
            p_tc_nxt       = (SPW'(p_cnt_r) > space_eff) ? {space_eff[3:2], 2'b00} : p_cnt_r;
            state_nxt      = ST_DATA;
          end
        end
      end

      // write up to four data bytes, one to each bank
      ST_DATA: begin
        chunk = (p_tc_r >= 4'd4) ? 3'd4 : p_tc_r[2:0];
        for (int j = 0; j < 4; j++) begin
          off        = 2'(j) - data_len_r[1:0];
          widx       = data_len_r + SPW'(off);
          bank_we[j] = ({1'b0, off} < chunk) && (widx < SPW'(FRAME_BYTES));
          bank_wa[j] = BAW'(widx >> 2);
          bank_wd[j] = top_bytes[8 * (3 - off) +: 8];
        end
        space_dn       = space_r - SPW'(chunk);
        data_len_nxt   = data_len_r + SPW'(chunk);
        space_nxt      = space_dn;
        open_count_nxt = open_count_r + 16'(chunk);
        p_cnt_nxt      = p_cnt_r - 4'(chunk);
        p_tc_nxt       = p_tc_r - 4'(chunk);
        p_bytes_nxt    = p_bytes_r << {chunk, 3'b000};
        if (p_tc_r == 4'(chunk)) begin
          if (space_dn < SPW'(5)) begin
            state_nxt = ST_EMIT;
            e_ret_nxt = (p_cnt_r == 4'(chunk)) ? p_ret_r : ST_HEAD;
            ew_nxt    = '0;
          end else begin
            state_nxt = (p_cnt_r == 4'(chunk)) ? p_ret_r : ST_HEAD;
          end
        end
      end

      // stream the frame out word by word
      ST_EMIT: begin
        if (ew_r < words) begin
          if (room) begin
            issue  = 1'b1;
            ew_nxt = ew_r + WW'(1);
          end
        end else if (!s2_v_r) begin
          frame_cnt_nxt  = frame_cnt_r + 8'd1;
          desc_total_nxt = '0;
          data_len_nxt   = '0;
          space_nxt      = SPW'(FRAME_BYTES);
          state_nxt      = e_ret_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand a pack call to the packer, or move to the next phase
    if (in_phase) begin
      if (call_v) begin
        p_type_nxt  = call_type;
        p_cnt_nxt   = call_cnt;
        p_bytes_nxt = call_bytes;
        p_ret_nxt   = phase_next;
        state_nxt   = ST_HEAD;
      end else begin
        state_nxt = phase_next;
      end
    end
  end

  // emission read addresses
  assign desc_ra    = DAW'(ew_r);
  assign bank_ra[0] = BAW'(ew_r - n_w);
  assign bank_ra[1] = BAW'(ew_r - n_w);
  assign bank_ra[2] = BAW'(ew_r - n_w - WW'(1));
  assign bank_ra[3] = BAW'(ew_r - n_w - WW'(1));

  // descriptor store: closed descriptors, the open one stays in registers
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_wa] <= '{cnt: open_count_r, typ: open_type_r};
    end
    desc_rd_r <= desc_mem[desc_ra];
  end

  // data byte store, four banks by byte offset
  for (genvar g = 0; g < 4; g++) begin : g_bank
    always_ff @(posedge clk) begin
      if (bank_we[g]) begin
        bank_mem[g][bank_wa[g]] <= bank_wd[g];
      end
      bank_rd_r[g] <= bank_mem[g][bank_ra[g]];
    end
  end

  // assemble one frame word from header fields and data banks
  always_comb begin
    cur_open  = (s2_w_r == n_w - WW'(1));
    cur_d     = cur_open ? '{cnt: open_count_r, typ: open_type_r} : desc_rd_r;
    cur_shown = (cur_d.typ == DT_LONG) ? (cur_d.cnt >> 2) : cur_d.cnt;
    if (s2_w_r == '0) begin
      ob[0] = 8'(16'(desc_total_r) >> 8);
      ob[1] = 8'(desc_total_r);
    end else if (s2_w_r <= n_w) begin
      ob[0] = 8'd0;
      ob[1] = {6'd0, t_prev_r};
    end else begin
      ob[0] = bank_rd_r[2];
      ob[1] = bank_rd_r[3];
    end
    if (s2_w_r < n_w) begin
      ob[2] = cur_shown[15:8];
      ob[3] = cur_shown[7:0];
    end else begin
      ob[2] = bank_rd_r[0];
      ob[3] = bank_rd_r[1];
    end
    rem_bytes = tot_bytes - SPW'({s2_w_r, 2'b00});
    vb        = (rem_bytes >= SPW'(4)) ? 3'd4 : rem_bytes[2:0];
    for (int i = 0; i < 4; i++) begin
      if (3'(i) >= vb) begin
        ob[i] = 8'd0;
      end
    end
    oq_data.frame_word      = {ob[0], ob[1], ob[2], ob[3]};
    oq_data.valid_bytes     = vb;
    oq_data.frame_last      = (s2_w_r == words - WW'(1));
    oq_data.sequence_number = frame_cnt_r[6:0];
    oq_push                 = s2_v_r;
    t_prev_nxt              = s2_v_r ? cur_d.typ : t_prev_r;
    s2_v_nxt                = issue;
    s2_w_nxt                = issue ? ew_r : s2_w_r;
  end

  // state and registered values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      p_ret_r      <= ST_IDLE;
      e_ret_r      <= ST_IDLE;
      chg_r        <= 1'b0;
      run_class_r  <= RC_NONE;
      pend_type_r  <= RC_NONE;
      pend_len_r   <= 4'd0;
      p_cnt_r      <= 4'd0;
      p_tc_r       <= 4'd0;
      desc_total_r <= '0;
      open_type_r  <= DT_BYTE;
      open_count_r <= 16'd0;
      space_r      <= SPW'(FRAME_BYTES);
      data_len_r   <= '0;
      frame_cnt_r  <= 8'd1;
      ew_r         <= '0;
      s2_v_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      p_ret_r      <= p_ret_nxt;
      e_ret_r      <= e_ret_nxt;
      chg_r        <= chg_nxt;
      run_class_r  <= run_class_nxt;
      pend_type_r  <= pend_type_nxt;
      pend_len_r   <= pend_len_nxt;
      p_cnt_r      <= p_cnt_nxt;
      p_tc_r       <= p_tc_nxt;
      desc_total_r <= desc_total_nxt;
      open_type_r  <= open_type_nxt;
      open_count_r <= open_count_nxt;
      space_r      <= space_nxt;
      data_len_r   <= data_len_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      ew_r         <= ew_nxt;
      s2_v_r       <= s2_v_nxt;
    end
    itm_r     <= itm_nxt;
    pend_b0_r <= pend_b0_nxt;
    pend_b1_r <= pend_b1_nxt;
    p_type_r  <= p_type_nxt;
    p_bytes_r <= p_bytes_nxt;
    s2_w_r    <= s2_w_nxt;
    t_prev_r  <= t_prev_nxt;
  end

endmodule

@@ rtl/detector_word_run_packer.sv @@
// Detector word run packer: packs 32-bit detector words into numbered frames.
// Input channel: queue-style; an item (operation, data_word, buffer_end) is
// taken on a clock edge with in_push high and in_full low. operation 1
// flushes the current frame; data words are sorted into zero, byte and long
// runs and packed into a frame of FRAME_BYTES bytes.
// Result channel: queue-style; while out_empty is low out_item holds the
// oldest frame word, taken on a clock edge with out_pop high.
// Configuration: APB-style port, register packing_enable at address 0.
// Throughput: a long word passes the packing sequencer as dispatch, word
// phase, descriptor step and one 4-byte write into the four byte banks;
// zero and small words take at most the same steps; a run close-out at a
// class change or buffer end adds a phase plus its packing steps. A frame
// streams one word per cycle while the result queue has room; each word
// passes a registered read stage before it enters the result queue.
// Reset: synchronous, active low; queues empty, frame empty, sequence
// counter at one, packing enabled.
// Stalls: when out_pop stays low the four-entry result queue fills, the
// emitter pauses, the two-entry input queue fills and in_full rises.
module detector_word_run_packer import dwrp_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             packing_enable_r;
  logic             q_valid, q_pop;
  cls_item_t        q_item;
  logic             oq_push;
  out_item_t        oq_data;
  logic [OQ_CW-1:0] oq_cnt;
  logic             cfg_wr;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_PACKING_ENABLE) ? {31'd0, packing_enable_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packing_enable_r <= 1'b1;
    end else if (cfg_wr && cfg_paddr[2] == REG_PACKING_ENABLE) begin
      packing_enable_r <= cfg_pwdata[0];
    end
  end

  dwrp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_item        (in_item),
    .packing_enable (packing_enable_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  dwrp_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .oq_cnt  (oq_cnt),
    .oq_push (oq_push),
    .oq_data (oq_data)
  );

  dwrp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_data),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (out_item),
    .cnt       (oq_cnt)
  );

endmodule

@@ rtl/dwrp_chk.sv @@
// port-level checks of the run packer, bound to the top level
module dwrp_chk import dwrp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input out_item_t   out_item
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // the input side takes items right after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

  // a frame word carries one to four bytes
  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.valid_bytes != 3'd0 && out_item.valid_bytes <= 3'd4))
    else $error("valid_bytes out of range");

  // a partial word can only close a frame
  a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.valid_bytes != 3'd4) |-> out_item.frame_last)
    else $error("partial word not marked last");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed");

endmodule

bind detector_word_run_packer dwrp_chk u_chk (.*);

@@ tb/sv/tb.sv @@
// testbench of the detector word run packer: directed table, random runs, frame checks
`timescale 1ns / 1ps

module tb;
  import dwrp_pkg::*;

  localparam int FB = FRAME_BYTES_DEF;
  localparam int DSLOTS = FB / 4 + 1;
  localparam int MAX_WORDS = 64;
  localparam int DRAIN_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  in_item_t    in_item;
  logic        out_empty;
  logic        out_pop;
  out_item_t   out_item;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  detector_word_run_packer uut (.*);

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // predictor state
  logic [7:0]  fstore [FB];
  logic [15:0] dcnt [DSLOTS];
  logic [1:0]  dtyp [DSLOTS];
  logic [7:0]  pend_bytes [2];
  bit          pack_on;
  int          ndesc, ocount, space, plen, fcount, dlen, step_words;
  logic [1:0]  otype;
  run_class_t  ptype, rclass;

  out_item_t   frame_words_q [$];
  int          errors, words_seen, items_sent;
  bit          idle_on;

  function automatic void save_open();
    if (ndesc > 0 && ndesc - 1 < DSLOTS) begin
      dcnt[ndesc-1] = ocount[15:0];
      dtyp[ndesc-1] = otype;
    end
  endfunction

  function automatic logic [7:0] frame_byte(int b, int n);
    int k;
    int r;
    logic [15:0] c;
    if (b < 2) return b == 0 ? n[15:8] : n[7:0];
    b -= 2;
    if (b < 4 * n) begin
      k = b / 4;
      r = b % 4;
      if (k >= DSLOTS) return 8'h00;
      c = dcnt[k];
      if (dtyp[k] == DT_LONG) c = c >> 2;
      case (r)
        0: return c[15:8];
        1: return c[7:0];
        2: return 8'h00;
        default: return {6'b0, dtyp[k]};
      endcase
    end
    b -= 4 * n;
    return b < FB ? fstore[b] : 8'h00;
  endfunction

  // stream the open frame out as words
  function automatic void emit_frame();
    int n, total, nwords, valid;
    logic [31:0] word;
    out_item_t o;
    n = ndesc;
    if (n == 0) return;
    save_open();
    total = 2 + 4 * n + dlen;
    nwords = (total + 3) / 4;
    for (int w = 0; w < nwords; w++) begin
      valid = total - 4 * w;
      if (valid > 4) valid = 4;
      word = '0;
      for (int i = 0; i < 4; i++)
        if (i < valid) word[31-8*i -: 8] = frame_byte(4 * w + i, n);
      if (step_words < MAX_WORDS) begin
        o.frame_word = word;
        o.valid_bytes = 3'(valid);
        o.frame_last = (w + 1 == nwords);
        o.sequence_number = fcount[6:0];
        frame_words_q.push_back(o);
        step_words++;
      end
    end
    fcount = (fcount + 1) & 255;
    ndesc = 0;
    dlen = 0;
    space = FB;
  endfunction

  function automatic void open_desc(logic [1:0] t);
    if (ndesc == 0) space = FB - 2;
    else save_open();
    ndesc++;
    ocount = 0;
    otype = t;
    space -= 4;
  endfunction

  // count is bytes for byte and long descriptors, elements for null ones
  function automatic void pack_run(logic [1:0] t, int count, logic [7:0] src [32]);
    int pos, tc;
    pos = 0;
    while (count > 0) begin
      if (ndesc == 0 || otype != t || ocount + count >= SPLIT_COUNT) begin
        if (space < 8) emit_frame();
        open_desc(t);
      end
      if (t != DT_NULL) begin
        tc = count > space ? (space & ~3) : count;
        for (int i = 0; i < tc; i++) begin
          if (dlen < FB) fstore[dlen] = src[pos+i];
          dlen++;
        end
        space -= tc;
        ocount += tc;
        count -= tc;
        pos += tc;
      end else begin
        ocount += count;
        count = 0;
      end
      if (space < 5) emit_frame();
    end
  endfunction

  function automatic void pack_long(logic [31:0] w);
    logic [7:0] b [32];
    b = '{default: 8'h00};
    for (int i = 0; i < 4; i++) b[i] = w[31-8*i -: 8];
    pack_run(DT_LONG, 4, b);
  endfunction

  // close a short pending zero or small run, choosing its type by look-ahead
  function automatic void close_pending(bit has, logic [31:0] look);
    logic [7:0] b [32];
    logic [1:0] t;
    bit empty;
    int len;
    b = '{default: 8'h00};
    len = plen;
    empty = (ndesc == 0);
    if (ptype == RC_ZERO && len > 0 && len <= ZERO_HOLD) begin
      t = DT_NULL;
      if (!empty && has) begin
        if (otype == DT_BYTE && look < 256) t = DT_BYTE;
        else if ((otype == DT_BYTE || look < 256) && len <= 4) t = DT_BYTE;
        else if (otype == DT_LONG && look >= 256 && len <= 2) t = DT_LONG;
      end else if (!has) begin
        if (otype == DT_BYTE && len < 4) t = DT_BYTE;
        else if (otype == DT_LONG && len < 2) t = DT_LONG;
      end else begin
        if (look < 256 && len < 4) t = DT_BYTE;
        else if (look >= 256 && len < 2) t = DT_LONG;
      end
      pack_run(t, t == DT_LONG ? 4 * len : len, b);
    end else if (ptype == RC_SMALL && len > 0 && len <= 2) begin
      t = DT_BYTE;
      if (!empty && has) begin
        if (otype == DT_LONG || look >= 256) t = DT_LONG;
      end else if (!has) begin
        if (otype == DT_LONG && len == 1) t = DT_LONG;
      end else begin
        if (look >= 256 && len == 1) t = DT_LONG;
      end
      if (t == DT_LONG) begin
        for (int i = 0; i < len; i++) b[4*i+3] = pend_bytes[i];
        pack_run(DT_LONG, 4 * len, b);
      end else begin
        b[0] = pend_bytes[0];
        b[1] = pend_bytes[1];
        pack_run(DT_BYTE, len, b);
      end
    end
    ptype = RC_NONE;
    plen = 0;
  endfunction

  function automatic void predictor_reset();
    pend_bytes = '{default: 8'h00};
    pack_on = 1'b1;
    ndesc = 0;
    otype = DT_BYTE;
    ocount = 0;
    space = FB;
    ptype = RC_NONE;
    plen = 0;
    fcount = 1;
    rclass = RC_NONE;
    dlen = 0;
  endfunction

  // predicted frame words for one accepted item
  function automatic void predict_item(in_item_t it, bit keep);
    logic [7:0] b [32];
    run_class_t c;
    logic [31:0] w;
    b = '{default: 8'h00};
    w = it.data_word;
    step_words = keep ? 0 : MAX_WORDS;
    if (it.operation) begin
      emit_frame();
      return;
    end
    if (!pack_on) begin
      close_pending(1'b0, '0);
      rclass = RC_NONE;
      pack_long(w);
      return;
    end
    c = (w == 0) ? RC_ZERO : (w < 256 ? RC_SMALL : RC_LONG);
    if (c != rclass) begin
      close_pending(1'b1, w);
      rclass = c;
      if (c == RC_LONG) pack_long(w);
      else begin
        ptype = c;
        plen = 1;
        pend_bytes[0] = w[7:0];
      end
    end else if (c == RC_LONG) begin
      pack_long(w);
    end else if (c == RC_ZERO) begin
      if (ptype == RC_ZERO) begin
        plen++;
        if (plen > ZERO_HOLD) begin
          pack_run(DT_NULL, plen, b);
          ptype = RC_NONE;
          plen = 0;
        end
      end else pack_run(DT_NULL, 1, b);
    end else begin
      if (ptype == RC_SMALL && plen < 2) begin
        pend_bytes[plen & 1] = w[7:0];
        plen++;
      end else if (ptype == RC_SMALL) begin
        b[0] = pend_bytes[0];
        b[1] = pend_bytes[1];
        b[2] = w[7:0];
        ptype = RC_NONE;
        plen = 0;
        pack_run(DT_BYTE, 3, b);
      end else begin
        b[0] = w[7:0];
        pack_run(DT_BYTE, 1, b);
      end
    end
    if (it.buffer_end) begin
      close_pending(1'b0, '0);
      rclass = RC_NONE;
    end
  endfunction

  // input transfer; push stays high between back-to-back items
  task automatic send_item(in_item_t it, bit keep);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    predict_item(it, keep);
    items_sent++;
  endtask

  task automatic send_word(logic [31:0] w, bit be);
    in_item_t it;
    it.operation = 1'b0;
    it.data_word = w;
    it.buffer_end = be;
    send_item(it, 1'b1);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (frame_words_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write: setup then access
  task automatic write_packing(bit en);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * REG_PACKING_ENABLE);
    cfg_pwdata <= {31'b0, en};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    pack_on = en;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // random runs with random content, some flushes and buffer ends
  task automatic random_runs(int n);
    int kind, len;
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 9);
      len = 1;
      if (kind == 0) begin
        it.operation = 1'b1;
        it.data_word = $urandom;
        it.buffer_end = $urandom_range(0, 1);
        send_item(it, 1'b1);
      end else begin
        if (kind <= 3) len = $urandom_range(1, 11);
        else if (kind <= 6) len = $urandom_range(1, 5);
        else len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          if (kind <= 3) it.data_word = '0;
          else if (kind <= 6) it.data_word = $urandom_range(1, 255);
          else it.data_word = $urandom | 32'h100;
          if (kind == 9) it.data_word = $urandom;
          it.operation = 1'b0;
          it.buffer_end = ($urandom_range(0, 7) == 0);
          send_item(it, 1'b1);
          k += (j > 0);
        end
      end
    end
  endtask

  typedef struct {
    in_item_t  it;
    int        ntyped;
    out_item_t t0;
    out_item_t t1;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // result side: compare each transfer, random stalls
  int stall_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        words_seen++;
        if (frame_words_q.size() == 0) begin
          $error("unexpected frame word %h", out_item.frame_word);
          errors++;
        end else begin
          automatic out_item_t e = frame_words_q.pop_front();
          if (out_item.frame_word !== e.frame_word) begin
            $error("frame_word exp %h act %h", e.frame_word, out_item.frame_word);
            errors++;
          end
          if (out_item.valid_bytes !== e.valid_bytes) begin
            $error("valid_bytes exp %0d act %0d", e.valid_bytes, out_item.valid_bytes);
            errors++;
          end
          if (out_item.frame_last !== e.frame_last) begin
            $error("frame_last exp %0d act %0d", e.frame_last, out_item.frame_last);
            errors++;
          end
          if (out_item.sequence_number !== e.sequence_number) begin
            $error("sequence_number exp %0d act %0d", e.sequence_number,
                   out_item.sequence_number);
            errors++;
          end
        end
      end
      if (!idle_on) out_pop <= 1'b1;
      else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_pop <= 1'b0;
      end else out_pop <= 1'b1;
    end
  end

  // watchdog on cycles with no transfer
  int quiet;
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d frame words outstanding", frame_words_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t fl;
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_item <= '0;
    out_pop <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    errors = 0;
    words_seen = 0;
    items_sent = 0;
    stall_left = 0;
    idle_on = 1'b1;
    fl = '{1'b1, 32'hFFFF_FFFF, 1'b1};
    predictor_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: flush on empty frame, one byte frame, then run edges
    dir_rows.push_back('{fl, 0, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'd5, 1'b1}, -1, '0, '0});
    dir_rows.push_back('{'{1'b1, 32'd0, 1'b0}, 2, '{32'h0001_0001, 3'd4, 1'b0, 7'd1},
                         '{32'h0000_0500, 3'd3, 1'b1, 7'd1}});
    dir_rows.push_back('{'{1'b0, 32'hFFFF_FFFF, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'h0000_0100, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'h0000_00FF, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'h8000_0000, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'd1, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'd2, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'd3, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'd0, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'd0, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'h1234_5678, 1'b1}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'd0, 1'b1}, -1, '0, '0});
    for (int i = 0; i < 9; i++) dir_rows.push_back('{'{1'b0, 32'd0, 1'b0}, -1, '0, '0});
    dir_rows.push_back('{'{1'b0, 32'd255, 1'b1}, -1, '0, '0});
    dir_rows.push_back('{fl, -1, '0, '0});
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it, dir_rows[i].ntyped < 0);
      if (dir_rows[i].ntyped > 0) frame_words_q.push_back(dir_rows[i].t0);
      if (dir_rows[i].ntyped > 1) frame_words_q.push_back(dir_rows[i].t1);
    end
    // sender holds off until every frame word is out
    wait_idle();

    // back-to-back zero run past the hold limit, then one zero at a time
    idle_on = 1'b0;
    for (int i = 0; i < ZERO_HOLD + 4; i++) send_word('0, 1'b0);
    send_word(32'd7, 1'b1);
    send_item(fl, 1'b1);
    idle_on = 1'b1;

    random_runs(20);
    wait_idle();
    write_packing(1'b0);
    random_runs(20);
    send_item(fl, 1'b1);
    wait_idle();
    write_packing(1'b1);
    random_runs(10);
    idle_on = 1'b0;
    random_runs(10);
    send_item(fl, 1'b1);
    in_push <= 1'b0;

    while (frame_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d input transfers and %0d frame words", items_sent, words_seen);
    $display("packing on and off, committed zero runs, flushes and input/output stalls");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
